[sv/kmer_window_minimizer_assert.svh]
// Assertion macros for the minimizer block.
`ifndef KMER_WINDOW_MINIMIZER_ASSERT_SVH
`define KMER_WINDOW_MINIMIZER_ASSERT_SVH
// hold a stalled transfer steady
`define KWM_HOLD(lbl, vld, stl, sig) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && stl) |=> (vld && $stable(sig))) else $error("stalled payload moved");
// implication check
`define KWM_IMPLY(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (a) |-> (b)) else $error("implication failed");
`endif

[sv/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared constants and types of the window minimizer.
// ----------------------------------------------------------------------------
package kwm_pkg;
  localparam int WINDOW_MAX = 16;
  localparam int POS_BITS   = 24;
  localparam int KMER_MAX   = 31;
  localparam int VAL_W      = 2 * KMER_MAX;
  localparam int QIDX_W     = $clog2(WINDOW_MAX + 1);
  localparam int FIFO_DEPTH = 2;

  localparam logic [0:0] REG_KMER_LENGTH  = 1'b0;
  localparam logic [0:0] REG_WINDOW_KMERS = 1'b1;

  typedef struct packed {
    logic [1:0] base_code;
    logic       base_ok;
    logic       seq_end;
  } base_t;

  typedef struct packed {
    logic             kmer_ok;
    logic             kmer_full;
    logic             win_full;
    logic             evict_ok;
    logic [POS_BITS-1:0] evict_pos;
    logic [POS_BITS-1:0] kmer_pos;
    logic [VAL_W-1:0] kmer_val;
    logic             seq_end;
    logic             overflow;
  } job_t;
endpackage

[sv/kwm_front.sv]
// ----------------------------------------------------------------------------
// kwm_front
// Rolling k-mer builder and position counter; classifies each base.
// ----------------------------------------------------------------------------
module kwm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  kwm_pkg::base_t       base_i,
  input  logic [4:0]           kmer_length_i,
  input  logic [4:0]           window_kmers_i,
  output kwm_pkg::job_t        job_o
);
  import kwm_pkg::*;

  logic [VAL_W-1:0]    roll_q, roll_d;
  logic [4:0]          run_q, run_d;
  logic [4:0]          run_n;
  logic [POS_BITS:0]   idx_q, idx_d;
  logic [5:0]          k_eff, w_eff;
  logic [VAL_W-1:0]    kmask;
  logic                live;
  logic [POS_BITS:0]   idx1, jpos;

  always_comb begin
    k_eff = (kmer_length_i == 5'd0) ? 6'd1 : {1'b0, kmer_length_i};
    w_eff = (window_kmers_i > 5'(WINDOW_MAX)) ? 6'(WINDOW_MAX) : {1'b0, window_kmers_i};
    kmask = ~({VAL_W{1'b1}} << {k_eff, 1'b0});
    live  = !idx_q[POS_BITS];
    idx1  = idx_q + 1'b1;
    jpos  = idx1 - (POS_BITS+1)'(k_eff);
    if (base_i.base_ok) begin
      run_n = (run_q < 5'd31) ? run_q + 5'd1 : run_q;
    end else begin
      run_n = '0;
    end
    roll_d = roll_q;
    run_d  = run_q;
    idx_d  = idx_q;
    if (live) begin
      if (base_i.base_ok) begin
        roll_d = ((roll_q << 2) | VAL_W'(base_i.base_code)) & kmask;
      end else begin
        roll_d = '0;
      end
      run_d = run_n;
      idx_d = idx1;
    end
    if (base_i.seq_end) begin
      roll_d = '0;
      run_d  = '0;
      idx_d  = '0;
    end
    job_o.kmer_full = live && (idx1 >= (POS_BITS+1)'(k_eff));
    job_o.kmer_ok   = job_o.kmer_full && ({1'b0, run_n} >= k_eff) && (w_eff != 6'd0);
    job_o.win_full  = (jpos + 1'b1) >= (POS_BITS+1)'(w_eff);
    job_o.evict_ok  = jpos >= (POS_BITS+1)'(w_eff);
    job_o.evict_pos = POS_BITS'(jpos - (POS_BITS+1)'(w_eff));
    job_o.kmer_pos  = jpos[POS_BITS-1:0];
    job_o.kmer_val  = ((roll_q << 2) | VAL_W'(base_i.base_code)) & kmask;
    job_o.seq_end   = base_i.seq_end;
    job_o.overflow  = live ? idx1[POS_BITS] : 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_q <= '0;
      run_q  <= '0;
      idx_q  <= '0;
    end else if (take_i) begin
      roll_q <= roll_d;
      run_q  <= run_d;
      idx_q  <= idx_d;
    end
  end
endmodule

[sv/kwm_fifo.sv]
// ----------------------------------------------------------------------------
// kwm_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module kwm_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  kwm_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output kwm_pkg::job_t job_o
);
  import kwm_pkg::*;

  job_t       mem_q [FIFO_DEPTH];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'(FIFO_DEPTH));
  assign empty_o = (cnt_q == 2'd0);
  assign job_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule

[sv/kwm_back.sv]
// ----------------------------------------------------------------------------
// kwm_back
// Monotone window queue, running best and result register.
// ----------------------------------------------------------------------------
module kwm_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    job_valid_i,
  input  kwm_pkg::job_t           job_i,
  output logic                    job_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [61:0]             min_kmer_o,
  output logic [kwm_pkg::POS_BITS-1:0] min_position_o,
  output logic                    min_found_o,
  output logic                    length_overflow_o
);
  import kwm_pkg::*;

  logic [VAL_W-1:0]    qv_q [WINDOW_MAX];
  logic [POS_BITS-1:0] qp_q [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] occ_q, occ_d;
  logic [VAL_W-1:0]    best_v_q;
  logic [POS_BITS-1:0] best_p_q;
  logic                best_f_q;
  logic                drop;
  logic [WINDOW_MAX-1:0] keep, occ_s;
  logic [VAL_W-1:0]    hv;
  logic [POS_BITS-1:0] hp;
  logic                hf;
  logic [QIDX_W-1:0]   n_keep;
  logic                res_ready;
  logic                upd;

  assign res_ready = !out_valid_o || !out_stall_i;
  assign job_pop_o = job_valid_i && (!job_i.seq_end || res_ready);

  always_comb begin
    drop = occ_q[0] && job_i.evict_ok && (qp_q[0] <= job_i.evict_pos);
    for (int i = 0; i < WINDOW_MAX; i++) begin
      occ_s[i] = drop ? ((i + 1 < WINDOW_MAX) ? occ_q[(i+1) % WINDOW_MAX] : 1'b0) : occ_q[i];
    end
    for (int i = 0; i < WINDOW_MAX; i++) begin
      keep[i] = occ_s[i] && (drop ? qv_q[(i+1) % WINDOW_MAX] : qv_q[i]) < job_i.kmer_val;
    end
    n_keep = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (keep[i]) n_keep = QIDX_W'(i + 1);
    end
    occ_d = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      occ_d[i] = QIDX_W'(i) <= n_keep;
    end
    if (n_keep != '0) begin
      hv = drop ? qv_q[1 % WINDOW_MAX] : qv_q[0];
      hp = drop ? qp_q[1 % WINDOW_MAX] : qp_q[0];
    end else begin
      hv = job_i.kmer_val;
      hp = job_i.kmer_pos;
    end
    hf  = 1'b1;
    upd = job_i.kmer_ok && job_i.win_full && hf && (!best_f_q || hv < best_v_q);
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o && job_i.kmer_ok) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
        if (QIDX_W'(i) < n_keep) begin
          qv_q[i] <= drop ? qv_q[(i+1) % WINDOW_MAX] : qv_q[i];
          qp_q[i] <= drop ? qp_q[(i+1) % WINDOW_MAX] : qp_q[i];
        end else if (QIDX_W'(i) == n_keep) begin
          qv_q[i] <= job_i.kmer_val;
          qp_q[i] <= job_i.kmer_pos;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      best_v_q    <= '0;
      best_p_q    <= '0;
      best_f_q    <= 1'b0;
      out_valid_o <= 1'b0;
      min_kmer_o  <= '0;
      min_position_o <= '0;
      min_found_o <= 1'b0;
      length_overflow_o <= 1'b0;
    end else begin
      if (job_pop_o && job_i.seq_end) begin
        out_valid_o       <= 1'b1;
        min_kmer_o        <= upd ? hv : (best_f_q ? best_v_q : '0);
        min_position_o    <= upd ? hp : (best_f_q ? best_p_q : '0);
        min_found_o       <= upd || best_f_q;
        length_overflow_o <= job_i.overflow;
        occ_q    <= '0;
        best_v_q <= '0;
        best_p_q <= '0;
        best_f_q <= 1'b0;
      end else begin
        if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
        if (job_pop_o) begin
          if (job_i.kmer_ok) occ_q <= occ_d;
          else if (job_i.kmer_full) occ_q <= '0;
          if (upd) begin
            best_v_q <= hv;
            best_p_q <= hp;
            best_f_q <= 1'b1;
          end
        end
      end
    end
  end
endmodule

[sv/kmer_window_minimizer.sv]
// ----------------------------------------------------------------------------
// kmer_window_minimizer
// Streaming k-mer window minimizer with APB configuration.
// ----------------------------------------------------------------------------
// channel  | direction | fields
// base     | in        | base_code, base_ok, seq_end
// result   | out       | min_kmer, min_position, min_found, length_overflow
// One base per cycle while the job queue has room; the front updates the rolling
// k-mer in the accepting cycle and the back updates the window queue when the
// job leaves a two-entry job queue. A result is registered in the back once
// its last base leaves the job queue unless an earlier result is still stalled.
// Reset clears all sequence state.
// A stalled result holds the next sequence end in the job queue; once the
// queue is full the input stalls.
// ----------------------------------------------------------------------------
module kmer_window_minimizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        base_valid_i,
  output logic        base_stall_o,
  input  logic [1:0]  base_code_i,
  input  logic        base_ok_i,
  input  logic        seq_end_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic [61:0] min_kmer_o,
  output logic [kwm_pkg::POS_BITS-1:0] min_position_o,
  output logic        min_found_o,
  output logic        length_overflow_o
);
  import kwm_pkg::*;

  logic [4:0] klen_q, wk_q;
  logic       take, full, empty, pop;
  base_t      base;
  job_t       job_in, job_out;

  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      REG_KMER_LENGTH:  prdata = {27'd0, klen_q};
      REG_WINDOW_KMERS: prdata = {27'd0, wk_q};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= 5'd15;
      wk_q   <= 5'd10;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_KMER_LENGTH:  klen_q <= pwdata[4:0];
        REG_WINDOW_KMERS: wk_q   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  assign base_stall_o = full;
  assign take = base_valid_i && !full;
  assign base = '{base_code: base_code_i, base_ok: base_ok_i, seq_end: seq_end_i};

  kwm_front u_front (
    .clk_i, .rst_ni, .take_i(take), .base_i(base),
    .kmer_length_i(klen_q), .window_kmers_i(wk_q), .job_o(job_in)
  );

  kwm_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(take), .job_i(job_in), .full_o(full),
    .pop_i(pop), .empty_o(empty), .job_o(job_out)
  );

  kwm_back u_back (
    .clk_i, .rst_ni, .job_valid_i(!empty), .job_i(job_out), .job_pop_o(pop),
    .out_valid_o(res_valid_o), .out_stall_i(res_stall_i),
    .min_kmer_o, .min_position_o, .min_found_o, .length_overflow_o
  );
endmodule

[sv/kwm_checker.sv]
// ----------------------------------------------------------------------------
// kwm_checker
// Port-level checks of the minimizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "kmer_window_minimizer_assert.svh"
module kwm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_o,
  input logic        res_stall_i,
  input logic [61:0] min_kmer_o,
  input logic [23:0] min_position_o,
  input logic        min_found_o,
  input logic        pready
);
  `KWM_HOLD(a_res_hold, res_valid_o, res_stall_i, min_kmer_o)
  `KWM_IMPLY(a_none_zero, res_valid_o && !min_found_o, min_kmer_o == '0 && min_position_o == '0)
  `KWM_IMPLY(a_pready, 1'b1, pready)
endmodule

bind kmer_window_minimizer kwm_checker u_kwm_checker (
  .clk_i, .rst_ni, .res_valid_o, .res_stall_i, .min_kmer_o, .min_position_o,
  .min_found_o, .pready
);

[sim/tb_kmer_window_minimizer.sv]
// ----------------------------------------------------------------------------
// tb_kmer_window_minimizer
// Self-checking bench for the streaming k-mer window minimizer. Bases are
// streamed with random gaps and output stalls. Each accepted base advances a
// behavioral model of the rolling k-mer, the monotone window queue and the
// running best, and every sequence end queues the expected result. The bench
// cycles through several register settings, the extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_kmer_window_minimizer;
  import kwm_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0]    kmer;
    logic [POS_BITS-1:0] pos;
    logic                found;
    logic                ovf;
  } minimizer_t;

  typedef struct {
    logic [1:0] code;
    logic       ok;
    logic       last;
    bit         typed;
    minimizer_t res;
  } base_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic base_valid_i = 1'b0;
  logic base_stall_o;
  logic [1:0] base_code_i = '0;
  logic base_ok_i = 1'b0;
  logic seq_end_i = 1'b0;
  logic res_valid_o;
  logic res_stall_i = 1'b0;
  logic [61:0] min_kmer_o;
  logic [POS_BITS-1:0] min_position_o;
  logic min_found_o;
  logic length_overflow_o;

  kmer_window_minimizer u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // model state
  logic [4:0] cfg_k, cfg_w;
  logic [VAL_W-1:0] roll;
  int unsigned run_len;
  longint unsigned base_idx;
  logic [VAL_W-1:0] win_val[WINDOW_MAX];
  logic [POS_BITS-1:0] win_pos[WINDOW_MAX];
  int unsigned win_n;
  logic [VAL_W-1:0] best_val;
  logic [POS_BITS-1:0] best_pos;
  bit best_ok;

  minimizer_t pending_q[$];
  int errors = 0;
  int sent = 0;
  bit quiet = 0;
  bit hold_req = 0;
  int hold_left = 0;

  task automatic clear_seq();
    roll = '0; run_len = 0; base_idx = 0; win_n = 0;
    best_val = '0; best_pos = '0; best_ok = 0;
  endtask

  task automatic shift_base(input logic [1:0] code, input logic ok);
    longint unsigned k, w, i, j;
    k = (cfg_k == 0) ? 1 : cfg_k;
    w = (cfg_w > WINDOW_MAX) ? WINDOW_MAX : cfg_w;
    i = base_idx;
    if (ok) begin
      roll = ((roll << 2) | code) & ((62'd1 << (2 * k)) - 1);
      if (run_len < 31) run_len++;
    end else begin
      roll = '0;
      run_len = 0;
    end
    base_idx = i + 1;
    if (i + 1 < k) return;
    j = i + 1 - k;
    if (run_len < k || w == 0) begin
      win_n = 0;
      return;
    end
    while (win_n > 0 && j >= w && win_pos[0] <= j - w) begin
      for (int t = 0; t + 1 < win_n; t++) begin
        win_val[t] = win_val[t+1];
        win_pos[t] = win_pos[t+1];
      end
      win_n--;
    end
    while (win_n > 0 && win_val[win_n-1] >= roll) win_n--;
    if (win_n < WINDOW_MAX) begin
      win_val[win_n] = roll;
      win_pos[win_n] = j[POS_BITS-1:0];
      win_n++;
    end
    if (j + 1 >= w && win_n > 0 && (!best_ok || win_val[0] < best_val)) begin
      best_val = win_val[0];
      best_pos = win_pos[0];
      best_ok = 1;
    end
  endtask

  task automatic predict_base(input logic [1:0] code, input logic ok, input logic last,
                              output bit has, output minimizer_t r);
    if (base_idx < (64'd1 << POS_BITS)) shift_base(code, ok);
    has = last;
    r = '0;
    if (last) begin
      if (best_ok) begin
        r.kmer = best_val; r.pos = best_pos; r.found = 1'b1;
      end
      r.ovf = (base_idx >= (64'd1 << POS_BITS));
      clear_seq();
    end
  endtask

  task automatic reg_write(input logic [0:0] idx, input logic [4:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {27'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_KMER_LENGTH) cfg_k = val;
    else cfg_w = val;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // transfer one base, return at the accepting edge
  task automatic send_base(input logic [1:0] code, input logic ok, input logic last,
                           input bit typed, input minimizer_t typed_res);
    int gap;
    bit has;
    minimizer_t r;
    gap = pick_gap();
    if (gap > 0) begin
      base_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    base_valid_i <= 1'b1;
    base_code_i <= code; base_ok_i <= ok; seq_end_i <= last;
    do @(posedge clk_i); while (base_stall_o);
    predict_base(code, ok, last, has, r);
    if (has) pending_q.insert(pending_q.size(), typed ? typed_res : r);
    sent++;
  endtask

  task automatic drain();
    base_valid_i <= 1'b0;
    while (pending_q.size() > 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic random_seq(input bit last_forced);
    int len, n_rate;
    minimizer_t none;
    none = '0;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 160) : $urandom_range(1, 45);
    n_rate = $urandom_range(0, 3);
    for (int b = 0; b < len; b++) begin
      logic ok;
      case (n_rate)
        0: ok = 1'b1;
        1: ok = ($urandom_range(0, 39) != 0);
        2: ok = ($urandom_range(0, 7) != 0);
        default: ok = ($urandom_range(0, 1) != 0);
      endcase
      send_base(2'($urandom_range(0, 3)), ok, (b == len - 1) || (!last_forced &&
                $urandom_range(0, 299) == 0), 0, none);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      res_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      res_stall_i <= 1'b1;
      hold_left <= 120;
      hold_req = 0;
    end else if (quiet) begin
      res_stall_i <= 1'b0;
    end else begin
      res_stall_i <= ($urandom_range(0, 99) < 30) ||
                     ($urandom_range(0, 199) == 0 && $urandom_range(0, 1) == 1);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result kmer=%h pos=%h", $time, min_kmer_o, min_position_o);
        errors++;
      end else begin
        minimizer_t e;
        e = pending_q[0];
        pending_q.delete(0);
        if (min_kmer_o !== e.kmer) begin
          $display("%0t: min_kmer exp %h got %h", $time, e.kmer, min_kmer_o);
          errors++;
        end
        if (min_position_o !== e.pos) begin
          $display("%0t: min_position exp %h got %h", $time, e.pos, min_position_o);
          errors++;
        end
        if (min_found_o !== e.found) begin
          $display("%0t: min_found exp %b got %b", $time, e.found, min_found_o);
          errors++;
        end
        if (length_overflow_o !== e.ovf) begin
          $display("%0t: length_overflow exp %b got %b", $time, e.ovf, length_overflow_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    base_row_t dir_tab[26];
    minimizer_t none;
    logic [4:0] k_set[10], w_set[10];
    none = '0;
    k_set = '{5'd1, 5'd31, 5'd0, 5'd31, 5'd2, 5'd1, 5'd31, 5'd3, 5'd4, 5'd1};
    w_set = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd16, 5'd1, 5'd17, 5'd5, 5'd2};
    cfg_k = 5'd15; cfg_w = 5'd10;
    clear_seq();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: too short for one k-mer, then a lone N
    dir_tab[0] = '{2'd0, 1'b1, 1'b1, 1, none};
    dir_tab[1] = '{2'd3, 1'b0, 1'b1, 1, none};
    for (int b = 0; b < 24; b++) begin
      dir_tab[b + 2] = '{(b < 12) ? 2'd3 : b[1:0], (b != 4), (b == 23), 0, none};
    end
    foreach (dir_tab[r]) send_base(dir_tab[r].code, dir_tab[r].ok, dir_tab[r].last,
                                   dir_tab[r].typed, dir_tab[r].res);
    drain();

    for (int ph = 0; sent < 1600; ph++) begin
      if (ph < 10) begin
        reg_write(REG_KMER_LENGTH, k_set[ph]);
        reg_write(REG_WINDOW_KMERS, w_set[ph]);
      end else begin
        if ($urandom_range(0, 1)) reg_write(REG_KMER_LENGTH, 5'($urandom_range(0, 31)));
        reg_write(REG_WINDOW_KMERS, ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                                : 5'($urandom_range(1, 16)));
      end
      quiet = (ph % 5 == 3);
      for (int s = 0; s < 4 && sent < 1600; s++) begin
        if (ph == 4 && s == 2) hold_req = 1;
        random_seq(1);
        if ($urandom_range(0, 5) == 0) drain();
      end
      quiet = 0;
      drain();
    end

    drain();
    if (errors == 0 && pending_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
